// ===== hdl/fixed_block_pool_allocator_top_macros.svh =====
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_TOP_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and off while rst_n is low.
`define FBPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and off while rst_n is low.
`define FBPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fbpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fbpa_pkg;

    localparam int FIELD_ADDR_W  = 32;
    localparam int LIMIT_W       = 9;
    localparam int LOG2_W        = 5;
    localparam int MAX_LOG2_N    = 16;

    localparam logic [LOG2_W-1:0] MIN_LOG2 = 5'd2;
    localparam logic [LOG2_W-1:0] MAX_LOG2 = 5'd16;

    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_RESET = 2'd2;

    localparam logic [2:0] ST_GRANTED   = 3'd0;
    localparam logic [2:0] ST_EXHAUSTED = 3'd1;
    localparam logic [2:0] ST_FREED     = 3'd2;
    localparam logic [2:0] ST_OUTSIDE   = 3'd3;
    localparam logic [2:0] ST_NONE      = 3'd4;

    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_LOG2  = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;

    localparam logic [31:0]        RST_BASE  = 32'd0;
    localparam logic [LOG2_W-1:0]  RST_LOG2  = 5'd2;
    localparam logic [LIMIT_W-1:0] RST_LIMIT = 9'd256;

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] free_address;
    } item_t;

    typedef struct packed {
        logic [31:0] granted_address;
        logic [2:0]  status;
        logic [8:0]  allocated_count;
    } result_t;

    typedef struct packed {
        logic [31:0]        base_address;
        logic [LOG2_W-1:0]  block_size_log2;
        logic [LIMIT_W-1:0] slot_limit;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/fbpa_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fbpa_regs
    import fbpa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                REG_BASE:  cfg_next.base_address    = pwdata;
                REG_LOG2:  cfg_next.block_size_log2 = pwdata[LOG2_W-1:0];
                REG_LIMIT: cfg_next.slot_limit      = pwdata[LIMIT_W-1:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_address    <= RST_BASE;
            cfg_reg.block_size_log2 <= RST_LOG2;
            cfg_reg.slot_limit      <= RST_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_BASE:  prdata = cfg_reg.base_address;
            REG_LOG2:  prdata = {{(32 - LOG2_W){1'b0}}, cfg_reg.block_size_log2};
            REG_LIMIT: prdata = {{(32 - LIMIT_W){1'b0}}, cfg_reg.slot_limit};
            default:   prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/fbpa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fbpa_ctrl
    import fbpa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        busy        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                busy        = 1'b1;
                cmd.execute = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/fbpa_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fbpa_dp
    import fbpa_pkg::*;
#(
    parameter int SLOTS     = 256,
    parameter int ADDR_BITS = 32
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire item_t     item,
    input  wire ctrl_cmd_t cmd,
    output logic           done,
    output result_t        result
);

    localparam int AW     = (ADDR_BITS < FIELD_ADDR_W) ? ADDR_BITS : FIELD_ADDR_W;
    localparam int CW     = $clog2(SLOTS + 1);
    localparam int IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SPAN_W = (AW > LIMIT_W + MAX_LOG2_N) ? AW : LIMIT_W + MAX_LOG2_N;

    item_t          item_reg;
    logic [CW-1:0]  depth_reg, depth_next;
    logic [CW-1:0]  wm_reg, wm_next;
    logic [CW-1:0]  count_reg, count_next;
    result_t        result_reg, result_next;
    logic           done_reg;

    logic [AW-1:0]  mem [SLOTS];
    logic [AW-1:0]  rd_data_reg;
    logic           we;
    logic [IW-1:0]  wr_idx;
    logic [IW-1:0]  rd_idx;
    logic [CW-1:0]  depth_m1;

    logic [LOG2_W-1:0] lg;
    logic [CW-1:0]     limit;
    logic [AW-1:0]     base_m;
    logic [AW-1:0]     addr_m;
    logic [AW-1:0]     fresh_addr;
    logic [SPAN_W-1:0] span;
    logic [SPAN_W-1:0] diff;
    logic              in_range;

    always_comb
    begin
        if (cfg.block_size_log2 < MIN_LOG2)
        begin
            lg = MIN_LOG2;
        end
        else if (cfg.block_size_log2 > MAX_LOG2)
        begin
            lg = MAX_LOG2;
        end
        else
        begin
            lg = cfg.block_size_log2;
        end
    end

    always_comb
    begin
        if (32'(cfg.slot_limit) > 32'(SLOTS))
        begin
            limit = CW'(SLOTS);
        end
        else
        begin
            limit = CW'(cfg.slot_limit);
        end
    end

    assign base_m     = cfg.base_address[AW-1:0];
    assign addr_m     = item_reg.free_address[AW-1:0];
    assign fresh_addr = base_m + (AW'(wm_reg) << lg);
    assign span       = (SPAN_W'(limit) - SPAN_W'(1)) << lg;
    assign diff       = SPAN_W'(addr_m - base_m);
    assign in_range   = (limit != '0) && (addr_m >= base_m) && (diff <= span);

    // The top of the freed stack is read every cycle, so it is ready when an item executes.
    assign depth_m1 = depth_reg - CW'(1);
    assign rd_idx   = depth_m1[IW-1:0];
    assign wr_idx   = depth_reg[IW-1:0];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_idx] <= addr_m;
        end
        rd_data_reg <= mem[rd_idx];
    end

    always_comb
    begin
        depth_next                  = depth_reg;
        wm_next                     = wm_reg;
        count_next                  = count_reg;
        we                          = 1'b0;
        result_next.granted_address = 32'd0;
        result_next.status          = ST_NONE;
        if (cmd.execute)
        begin
            case (item_reg.kind)
                KIND_ALLOC:
                begin
                    if (count_reg >= limit)
                    begin
                        result_next.status = ST_EXHAUSTED;
                    end
                    else if (depth_reg != '0)
                    begin
                        result_next.granted_address = 32'(rd_data_reg);
                        result_next.status          = ST_GRANTED;
                        depth_next                  = depth_reg - CW'(1);
                        count_next                  = count_reg + CW'(1);
                    end
                    else if (wm_reg < limit)
                    begin
                        result_next.granted_address = 32'(fresh_addr);
                        result_next.status          = ST_GRANTED;
                        wm_next                     = wm_reg + CW'(1);
                        count_next                  = count_reg + CW'(1);
                    end
                    else
                    begin
                        result_next.status = ST_EXHAUSTED;
                    end
                end
                KIND_FREE:
                begin
                    if (!in_range)
                    begin
                        result_next.status = ST_OUTSIDE;
                    end
                    else if ((count_reg == '0) || (depth_reg >= CW'(SLOTS)))
                    begin
                        result_next.status = ST_NONE;
                    end
                    else
                    begin
                        we                 = 1'b1;
                        depth_next         = depth_reg + CW'(1);
                        count_next         = count_reg - CW'(1);
                        result_next.status = ST_FREED;
                    end
                end
                KIND_RESET:
                begin
                    depth_next = '0;
                    wm_next    = '0;
                    count_next = '0;
                end
                default:
                begin
                    result_next.status = ST_NONE;
                end
            endcase
        end
        result_next.allocated_count = 9'(count_next);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.execute)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            wm_reg    <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            depth_reg <= depth_next;
            wm_reg    <= wm_next;
            count_reg <= count_next;
            done_reg  <= cmd.execute;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ===== hdl/fixed_block_pool_allocator_top.sv =====
// Channel   Handshake                 Payload
// item      start in, busy out        item   (item_t: kind, free_address)
// result    done out (one cycle)      result (result_t: granted_address, status,
//                                             allocated_count)
// config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// An item is taken when start is high and busy is low; busy is high for the next
// cycle while the item executes, and done with its result follows in the cycle after.
// No new item is accepted while busy is high; the registered top of the freed-address stack
// must reflect the previous item before the next one runs. rst_n clears the counters and
// loads the config defaults; item and result registers and stack memory are not reset.
// The result receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "fixed_block_pool_allocator_top_macros.svh"

module fixed_block_pool_allocator_top
    import fbpa_pkg::*;
#(
    parameter int SLOTS     = 256,
    parameter int ADDR_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire item_t       item,
    output logic             done,
    output result_t          result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    cfg_t      cfg;
    ctrl_cmd_t cmd;

    fbpa_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fbpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    fbpa_dp #(
        .SLOTS     (SLOTS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    `FBPA_ASSERT_NEXT(a_accept_runs, start && !busy, busy && cmd.execute, "accepted item did not execute")
    `FBPA_ASSERT_NEXT(a_exec_reports, busy, done && !busy, "executed item gave no result")
    `FBPA_ASSERT_NOW(a_done_follows, done, $past(busy), "result without an executed item")
    `FBPA_ASSERT_NOW(a_zero_addr, done && (result.status != ST_GRANTED), result.granted_address == 32'd0, "address on a result without grant")

endmodule

`default_nettype wire
